### rtl/pfb_pkg.sv
package pfb_pkg;

    // Canvas geometry
    localparam int CANVAS_WIDTH  = 84;
    localparam int CANVAS_HEIGHT = 48;
    localparam int PAGE_COUNT    = CANVAS_HEIGHT / 8;
    localparam int STORE_DEPTH   = CANVAS_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    // page counter reaches one past the highest page a row field can name
    localparam int PAGE_W        = 6;

    // Command codes
    typedef enum logic [2:0] {
        FUNC_CLEAR = 3'd0,
        FUNC_FILL  = 3'd1,
        FUNC_ERASE = 3'd2,
        FUNC_BLIT  = 3'd3,
        FUNC_READ  = 3'd4
    } func_t;

    // Blit raster ops
    typedef enum logic [1:0] {
        ROP_AND = 2'd0,
        ROP_OR  = 2'd1,
        ROP_XOR = 2'd2
    } rop_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_WIPE,
        ST_RECT_PAGE,
        ST_RECT_RD,
        ST_RECT_WR,
        ST_BLIT_CHK,
        ST_BLIT_RD,
        ST_BLIT_WR,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic wipe;
        logic clr_step;
        logic page_start;
        logic page_next;
        logic col_next;
        logic blit_second;
        logic mem_rd;
        logic mem_wr;
        logic rd_latch;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic       clr_last;
        logic       mask_zero;
        logic       col_done;
        logic       page_last;
        logic       page_ok;
        logic       blit_skip;
        logic       cov_zero;
        logic       second;
        logic       read_ok;
        logic       out_free;
    } dp_stat_t;

endpackage

### rtl/pfb_intf.sv
interface pfb_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic [7:0] sprite_byte;
    logic [3:0] valid_rows;
    logic [1:0] raster_op;

    modport source (
        output valid, func, col, row, rect_width, rect_height,
               sprite_byte, valid_rows, raster_op,
        input  ready
    );
    modport sink (
        input  valid, func, col, row, rect_width, rect_height,
               sprite_byte, valid_rows, raster_op,
        output ready
    );
endinterface

interface pfb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (
        output valid, read_data,
        input  ready
    );
    modport sink (
        input  valid, read_data,
        output ready
    );
endinterface

### rtl/pfb_ctrl.sv
module pfb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pfb_pkg::dp_stat_t stat,
    output pfb_pkg::dp_cmd_t  cmd
);

    pfb_pkg::state_t state_reg;
    pfb_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfb_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            pfb_pkg::ST_INIT:
            begin
                cmd.wipe     = 1'b1;
                cmd.mem_wr   = 1'b1;
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = pfb_pkg::ST_IDLE;
                end
            end
            pfb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = pfb_pkg::ST_DISPATCH;
                end
            end
            pfb_pkg::ST_DISPATCH:
            begin
                case (stat.func)
                    pfb_pkg::FUNC_CLEAR:
                    begin
                        state_next = pfb_pkg::ST_WIPE;
                    end
                    pfb_pkg::FUNC_FILL, pfb_pkg::FUNC_ERASE:
                    begin
                        cmd.page_start = 1'b1;
                        state_next     = pfb_pkg::ST_RECT_PAGE;
                    end
                    pfb_pkg::FUNC_BLIT:
                    begin
                        state_next = stat.blit_skip ? pfb_pkg::ST_DONE
                                                    : pfb_pkg::ST_BLIT_CHK;
                    end
                    pfb_pkg::FUNC_READ:
                    begin
                        state_next = stat.read_ok ? pfb_pkg::ST_READ_RD
                                                  : pfb_pkg::ST_DONE;
                    end
                    default:
                    begin
                        state_next = pfb_pkg::ST_DONE;
                    end
                endcase
            end
            pfb_pkg::ST_WIPE:
            begin
                cmd.wipe     = 1'b1;
                cmd.mem_wr   = 1'b1;
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = pfb_pkg::ST_DONE;
                end
            end
            // one page at a time, skipping pages the rectangle misses
            pfb_pkg::ST_RECT_PAGE:
            begin
                if (stat.mask_zero || stat.col_done)
                begin
                    if (stat.page_last)
                    begin
                        state_next = pfb_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.page_next = 1'b1;
                    end
                end
                else
                begin
                    state_next = pfb_pkg::ST_RECT_RD;
                end
            end
            pfb_pkg::ST_RECT_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = pfb_pkg::ST_RECT_WR;
            end
            pfb_pkg::ST_RECT_WR:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.col_next = 1'b1;
                state_next   = pfb_pkg::ST_RECT_PAGE;
            end
            // upper page first, then the page below
            pfb_pkg::ST_BLIT_CHK:
            begin
                if (stat.page_ok && !stat.cov_zero)
                begin
                    state_next = pfb_pkg::ST_BLIT_RD;
                end
                else if (stat.second)
                begin
                    state_next = pfb_pkg::ST_DONE;
                end
                else
                begin
                    cmd.page_next   = 1'b1;
                    cmd.blit_second = 1'b1;
                end
            end
            pfb_pkg::ST_BLIT_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = pfb_pkg::ST_BLIT_WR;
            end
            pfb_pkg::ST_BLIT_WR:
            begin
                cmd.mem_wr = 1'b1;
                if (stat.second)
                begin
                    state_next = pfb_pkg::ST_DONE;
                end
                else
                begin
                    cmd.page_next   = 1'b1;
                    cmd.blit_second = 1'b1;
                    state_next      = pfb_pkg::ST_BLIT_CHK;
                end
            end
            pfb_pkg::ST_READ_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = pfb_pkg::ST_READ_WAIT;
            end
            pfb_pkg::ST_READ_WAIT:
            begin
                cmd.rd_latch = 1'b1;
                state_next   = pfb_pkg::ST_DONE;
            end
            // hand the result to the output register once it is free
            pfb_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = pfb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/pfb_datapath.sv
module pfb_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [2:0]        func,
    input  logic [7:0]        col,
    input  logic [7:0]        row,
    input  logic [7:0]        rect_width,
    input  logic [7:0]        rect_height,
    input  logic [7:0]        sprite_byte,
    input  logic [3:0]        valid_rows,
    input  logic [1:0]        raster_op,
    input  pfb_pkg::dp_cmd_t  cmd,
    output pfb_pkg::dp_stat_t stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_data
);

    // Captured command
    logic [2:0]                   func_reg;
    logic [7:0]                   left_reg;
    logic [7:0]                   top_reg;
    logic [7:0]                   w_reg;
    logic [7:0]                   h_reg;
    logic [7:0]                   data_reg;
    logic [3:0]                   nvalid_reg;
    logic [1:0]                   op_reg;

    // Walk state
    logic [pfb_pkg::PAGE_W-1:0]   page_reg;
    logic [pfb_pkg::ADDR_W-1:0]   base_reg;
    logic [8:0]                   col_reg;
    logic                         second_reg;
    logic [pfb_pkg::ADDR_W-1:0]   clr_reg;

    // Store and result
    logic [7:0]                   canvas_mem [pfb_pkg::STORE_DEPTH];
    logic [7:0]                   rd_data_reg;
    logic [7:0]                   res_reg;
    logic                         out_valid_reg;
    logic [7:0]                   out_data_reg;

    logic [8:0]                   right_sum;
    logic [8:0]                   right_edge;
    logic [8:0]                   hi_row;
    logic [7:0]                   rect_mask;
    logic [3:0]                   n_rows;
    logic [15:0]                  spr16;
    logic [15:0]                  pad16;
    logic [15:0]                  cov16;
    logic [7:0]                   spr;
    logic [7:0]                   pad;
    logic [7:0]                   cov;
    logic [pfb_pkg::ADDR_W-1:0]   byte_addr;
    logic [pfb_pkg::ADDR_W-1:0]   mem_addr;
    logic [7:0]                   wdata;
    logic                         page_ok;

    // Rectangle column bound, clipped to the canvas
    assign right_sum  = {1'b0, left_reg} + {1'b0, w_reg};
    assign right_edge = (right_sum > 9'(pfb_pkg::CANVAS_WIDTH))
                      ? 9'(pfb_pkg::CANVAS_WIDTH) : right_sum;
    assign hi_row     = {1'b0, top_reg} + {1'b0, h_reg};

    // Rows of the current page covered by the rectangle
    always_comb
    begin
        logic [8:0] r;
        rect_mask = '0;
        for (int k = 0; k < 8; k++)
        begin
            r = {page_reg, 3'(k)};
            rect_mask[7-k] = (r >= {1'b0, top_reg}) && (r < hi_row);
        end
    end

    // Sprite byte split across two pages
    assign n_rows = (nvalid_reg > 4'd8) ? 4'd8 : nvalid_reg;
    assign spr16  = {data_reg, 8'h00} >> top_reg[2:0];
    assign pad16  = {8'hff >> n_rows, 8'h00} >> top_reg[2:0];
    assign cov16  = 16'hff00 >> top_reg[2:0];
    assign spr    = second_reg ? spr16[7:0] : spr16[15:8];
    assign pad    = second_reg ? pad16[7:0] : pad16[15:8];
    assign cov    = second_reg ? cov16[7:0] : cov16[15:8];

    assign page_ok   = page_reg < pfb_pkg::PAGE_W'(pfb_pkg::PAGE_COUNT);
    assign byte_addr = base_reg + pfb_pkg::ADDR_W'(col_reg);
    assign mem_addr  = cmd.wipe ? clr_reg : byte_addr;

    // Modified byte
    always_comb
    begin
        wdata = rd_data_reg;
        if (cmd.wipe)
        begin
            wdata = 8'h00;
        end
        else
        begin
            case (func_reg)
                pfb_pkg::FUNC_FILL:  wdata = rd_data_reg | rect_mask;
                pfb_pkg::FUNC_ERASE: wdata = rd_data_reg & ~rect_mask;
                pfb_pkg::FUNC_BLIT:
                begin
                    case (op_reg)
                        pfb_pkg::ROP_AND: wdata = rd_data_reg & (spr | pad | ~cov);
                        pfb_pkg::ROP_OR:  wdata = rd_data_reg | spr;
                        pfb_pkg::ROP_XOR: wdata = rd_data_reg ^ spr;
                        default:          wdata = rd_data_reg;
                    endcase
                end
                default: wdata = rd_data_reg;
            endcase
        end
    end

    // Command capture and walk counters
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= func;
            left_reg   <= col;
            top_reg    <= row;
            w_reg      <= rect_width;
            h_reg      <= rect_height;
            data_reg   <= sprite_byte;
            nvalid_reg <= valid_rows;
            op_reg     <= raster_op;
            page_reg   <= {1'b0, row[7:3]};
            base_reg   <= pfb_pkg::ADDR_W'(row[7:3] * pfb_pkg::CANVAS_WIDTH);
            col_reg    <= {1'b0, col};
            second_reg <= 1'b0;
            res_reg    <= 8'h00;
        end
        if (cmd.page_start)
        begin
            page_reg <= '0;
            base_reg <= '0;
            col_reg  <= {1'b0, left_reg};
        end
        if (cmd.page_next)
        begin
            page_reg <= page_reg + 1'b1;
            base_reg <= base_reg + pfb_pkg::ADDR_W'(pfb_pkg::CANVAS_WIDTH);
            col_reg  <= {1'b0, left_reg};
        end
        if (cmd.col_next)
        begin
            col_reg <= col_reg + 9'd1;
        end
        if (cmd.blit_second)
        begin
            second_reg <= 1'b1;
        end
        if (cmd.rd_latch)
        begin
            res_reg <= rd_data_reg;
        end
    end

    // Canvas store, one access per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            canvas_mem[mem_addr] <= wdata;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= canvas_mem[mem_addr];
        end
    end

    // Clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_reg <= stat.clr_last ? '0 : clr_reg + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Status to the controller
    assign stat.func      = func_reg;
    assign stat.clr_last  = clr_reg == pfb_pkg::ADDR_W'(pfb_pkg::STORE_DEPTH - 1);
    assign stat.mask_zero = rect_mask == 8'h00;
    assign stat.col_done  = col_reg >= right_edge;
    assign stat.page_last = page_reg == pfb_pkg::PAGE_W'(pfb_pkg::PAGE_COUNT - 1);
    assign stat.page_ok   = page_ok;
    assign stat.blit_skip = ({1'b0, left_reg} >= 9'(pfb_pkg::CANVAS_WIDTH))
                         || (op_reg != pfb_pkg::ROP_AND && op_reg != pfb_pkg::ROP_OR
                             && op_reg != pfb_pkg::ROP_XOR);
    assign stat.cov_zero  = cov == 8'h00;
    assign stat.second    = second_reg;
    assign stat.read_ok   = ({1'b0, left_reg} < 9'(pfb_pkg::CANVAS_WIDTH)) && page_ok;
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Checks
    a_no_rd_wr_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_rd && cmd.mem_wr))
        else $error("canvas read and write in the same cycle");

    a_access_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_rd || (cmd.mem_wr && !cmd.wipe)) |->
            (page_ok && col_reg < 9'(pfb_pkg::CANVAS_WIDTH)))
        else $error("canvas access outside the canvas");

    a_col_step_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.col_next |-> (col_reg < right_edge))
        else $error("rectangle column stepped past its right edge");

    a_load_needs_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

endmodule

### rtl/page_framebuffer_blitter_core.sv
// Monochrome page framebuffer, 84 x 48 pixels kept as 8-pixel vertical bytes
// (MSB = top pixel) in a single-port 504-byte store. After reset the store is
// swept to zero, and no command transfer is taken until the sweep ends. Each
// command gives one response transfer: the byte for a read, zero otherwise.
// Commands work through the one store port: fill, erase and blit read,
// modify and write back each byte they touch, clear writes zero to every
// byte, and read fetches one byte.
// The next command is taken while an earlier response still waits.
module page_framebuffer_blitter_core (
    input  logic      clk,
    input  logic      rst_n,
    pfb_req_if.sink   req,
    pfb_rsp_if.source rsp
);

    pfb_pkg::dp_cmd_t  dp_cmd;
    pfb_pkg::dp_stat_t dp_stat;
    logic              in_ready;

    assign req.ready = in_ready;

    pfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    pfb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .func        (req.func),
        .col         (req.col),
        .row         (req.row),
        .rect_width  (req.rect_width),
        .rect_height (req.rect_height),
        .sprite_byte (req.sprite_byte),
        .valid_rows  (req.valid_rows),
        .raster_op   (req.raster_op),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_data    (rsp.read_data)
    );

endmodule
